// ----- rtl/ldt_pkg.sv -----
// Shared types and constants for the labeled detection track table.
// Holds entry layout, opcodes, result kinds and the controller/datapath structs.
// No dependencies.
package ldt_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int POS_W    = 32;
  localparam int LAB_W    = 8;
  localparam int HIT_W    = 16;
  localparam int CFG_W    = 16;
  localparam int SLOT_W   = 5;
  localparam int USED_W   = 6;
  localparam int KIND_W   = 3;
  localparam int OP_W     = 2;
  localparam int CIDX_W   = 2;

  // magnitude of pos*n + det, and divisor n+1
  localparam int NUM_W    = 48;
  localparam int DIVR_W   = 17;

  localparam logic [HIT_W-1:0] HITS_MAX = '1;
  localparam logic [LAB_W-1:0] LABEL_UNKNOWN = '0;

  localparam logic [OP_W-1:0] OP_DET = 2'd0;
  localparam logic [OP_W-1:0] OP_PUB = 2'd1;
  localparam logic [OP_W-1:0] OP_RST = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;

  localparam logic [CIDX_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_MIN    = 2'd1;

  localparam logic [KIND_W-1:0] KIND_MERGED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADDED  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DROP   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MAP    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_RESET  = 3'd5;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [LAB_W-1:0]        label;
    logic [HIT_W-1:0]        hits;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

  typedef struct packed {
    logic              capture;
    logic              idx_clr;
    logic              idx_inc;
    logic              addr_sel;
    logic              diff_en;
    logic              sq_en;
    logic              gate_upd;
    logic              mul_en;
    logic              div_start;
    logic              pub_upd;
    logic              res_load;
    logic [KIND_W-1:0] res_kind;
  } cmd_t;

  typedef struct packed {
    logic occ_zero;
    logic full;
    logic idx_end;
    logic hit_eq;
    logic sel_valid;
    logic qual;
    logic any_q;
    logic is_last;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

// ----- rtl/ldt_ram.sv -----
// Generic single write port RAM with one registered read port.
// No dependencies.
module ldt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/ldt_div.sv -----
// Three-lane restoring divider, one quotient bit per cycle, shared divisor.
// Depends on ldt_pkg.
module ldt_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [2:0][ldt_pkg::NUM_W-1:0]       dividend,
  input  logic [ldt_pkg::DIVR_W-1:0]           divisor,
  output logic [2:0][ldt_pkg::NUM_W-1:0]       quot,
  output logic                                 done
);
  import ldt_pkg::*;

  localparam int CW = $clog2(NUM_W);

  logic                    busy;
  logic [CW-1:0]           cnt;
  logic [DIVR_W-1:0]       dvs;
  logic [2:0][DIVR_W:0]    rem;
  logic [2:0][NUM_W-1:0]   q;
  logic [2:0][DIVR_W:0]    rem_next;
  logic [2:0][NUM_W-1:0]   q_next;

  always_comb begin
    logic [DIVR_W:0] r;
    for (int l = 0; l < 3; l++) begin
      r = {rem[l][DIVR_W-1:0], q[l][NUM_W-1]};
      if (r >= {1'b0, dvs}) begin
        rem_next[l] = r - {1'b0, dvs};
        q_next[l]   = {q[l][NUM_W-2:0], 1'b1};
      end else begin
        rem_next[l] = r;
        q_next[l]   = {q[l][NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      q   <= dividend;
      rem <= '0;
    end else if (busy) begin
      q   <= q_next;
      rem <= rem_next;
    end
  end

  assign quot = q;

endmodule

// ----- rtl/ldt_ctrl.sv -----
// Controller state machine: sequences gating scan, mean update, publish and reset.
// Depends on ldt_pkg; drives the datapath through cmd_t and reads stat_t.
module ldt_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [ldt_pkg::OP_W-1:0] op,
  output logic                    in_ready,
  input  ldt_pkg::stat_t          stat,
  output ldt_pkg::cmd_t           cmd
);
  import ldt_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DRD    = 5'd1;
  localparam logic [4:0] S_DDIFF  = 5'd2;
  localparam logic [4:0] S_DSQ    = 5'd3;
  localparam logic [4:0] S_DCMP   = 5'd4;
  localparam logic [4:0] S_DEND   = 5'd5;
  localparam logic [4:0] S_MRD    = 5'd6;
  localparam logic [4:0] S_MMUL   = 5'd7;
  localparam logic [4:0] S_MSTART = 5'd8;
  localparam logic [4:0] S_MWAIT  = 5'd9;
  localparam logic [4:0] S_MWR    = 5'd10;
  localparam logic [4:0] S_NEW    = 5'd11;
  localparam logic [4:0] S_PRD    = 5'd12;
  localparam logic [4:0] S_PCHK   = 5'd13;
  localparam logic [4:0] S_QRD    = 5'd14;
  localparam logic [4:0] S_QCHK   = 5'd15;
  localparam logic [4:0] S_EMPTY  = 5'd16;
  localparam logic [4:0] S_RST    = 5'd17;

  logic [4:0] state;
  logic [4:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (op)
            OP_DET:  state_next = stat.occ_zero ? S_NEW : S_DRD;
            OP_PUB:  state_next = stat.occ_zero ? S_EMPTY : S_PRD;
            OP_RST:  state_next = S_RST;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_DRD:   state_next = S_DDIFF;
      S_DDIFF: begin
        cmd.diff_en = 1'b1;
        state_next  = S_DSQ;
      end
      S_DSQ: begin
        cmd.sq_en  = 1'b1;
        state_next = S_DCMP;
      end
      S_DCMP: begin
        cmd.gate_upd = 1'b1;
        if (stat.hit_eq) begin
          state_next = S_MRD;
        end else if (stat.idx_end) begin
          state_next = S_DEND;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_DRD;
        end
      end
      S_DEND: state_next = stat.sel_valid ? S_MRD : S_NEW;
      S_MRD: begin
        cmd.addr_sel = 1'b1;
        state_next   = S_MMUL;
      end
      S_MMUL: begin
        cmd.addr_sel = 1'b1;
        cmd.mul_en   = 1'b1;
        state_next   = S_MSTART;
      end
      S_MSTART: begin
        cmd.addr_sel  = 1'b1;
        cmd.div_start = 1'b1;
        state_next    = S_MWAIT;
      end
      S_MWAIT: begin
        cmd.addr_sel = 1'b1;
        if (stat.div_done) begin
          state_next = S_MWR;
        end
      end
      S_MWR: begin
        cmd.addr_sel = 1'b1;
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = KIND_MERGED;
          state_next   = S_IDLE;
        end
      end
      S_NEW: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = stat.full ? KIND_DROP : KIND_ADDED;
          state_next   = S_IDLE;
        end
      end
      S_PRD: state_next = S_PCHK;
      S_PCHK: begin
        cmd.pub_upd = 1'b1;
        if (stat.idx_end) begin
          if (stat.any_q || stat.qual) begin
            cmd.idx_clr = 1'b1;
            state_next  = S_QRD;
          end else begin
            state_next = S_EMPTY;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_PRD;
        end
      end
      S_QRD: state_next = S_QCHK;
      S_QCHK: begin
        if (stat.qual) begin
          if (stat.out_free) begin
            cmd.res_load = 1'b1;
            cmd.res_kind = KIND_MAP;
            if (stat.is_last) begin
              state_next = S_IDLE;
            end else begin
              cmd.idx_inc = 1'b1;
              state_next  = S_QRD;
            end
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_QRD;
        end
      end
      S_EMPTY: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = KIND_EMPTY;
          state_next   = S_IDLE;
        end
      end
      S_RST: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = KIND_RESET;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/ldt_datapath.sv -----
// Datapath: track RAM, gate arithmetic, running mean, config and result register.
// Depends on ldt_pkg, ldt_ram and ldt_div.
module ldt_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  ldt_pkg::cmd_t                      cmd,
  output ldt_pkg::stat_t                     stat,
  input  logic signed [ldt_pkg::POS_W-1:0]   det_x,
  input  logic signed [ldt_pkg::POS_W-1:0]   det_y,
  input  logic signed [ldt_pkg::POS_W-1:0]   det_z,
  input  logic [ldt_pkg::LAB_W-1:0]          det_label,
  input  logic                               cfg_we,
  input  logic [ldt_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [ldt_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [ldt_pkg::KIND_W-1:0]         kind,
  output logic [ldt_pkg::SLOT_W-1:0]         slot,
  output logic signed [ldt_pkg::POS_W-1:0]   pos_x,
  output logic signed [ldt_pkg::POS_W-1:0]   pos_y,
  output logic signed [ldt_pkg::POS_W-1:0]   pos_z,
  output logic [ldt_pkg::LAB_W-1:0]          label_out,
  output logic [ldt_pkg::HIT_W-1:0]          count_out,
  output logic [ldt_pkg::USED_W-1:0]         entries_used,
  output logic                               last
);
  import ldt_pkg::*;

  logic signed [POS_W-1:0] dx_r, dy_r, dz_r;
  logic [LAB_W-1:0]        dlab_r;
  logic [CNT_W-1:0]        idx;
  logic [CNT_W-1:0]        occ;
  logic [IDX_W-1:0]        sel;
  logic                    sel_valid;
  logic [IDX_W-1:0]        last_idx;
  logic                    any_q;
  logic [CFG_W-1:0]        min_det;
  logic [2*CFG_W-1:0]      r2;
  logic [15:0]             adx, ady;
  logic                    far;
  logic [31:0]             dx2, dy2;
  logic [2:0][NUM_W-1:0]   mag;
  logic [2:0]              neg;

  entry_t                  ent;
  entry_t                  wr_ent;
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [IDX_W-1:0]        ram_raddr;

  logic [2:0][NUM_W-1:0]   quot;
  logic                    div_done;

  logic                    gate;
  logic                    lab_eq;
  logic                    side;
  logic signed [POS_W-1:0] mx, my, mz;
  logic [LAB_W-1:0]        new_lab;
  logic [HIT_W-1:0]        new_hits;
  logic [CNT_W-1:0]        idx_inc1;

  assign ram_raddr = cmd.addr_sel ? sel : idx[IDX_W-1:0];

  ldt_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_ent),
    .raddr (ram_raddr),
    .rdata (ent)
  );

  ldt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (mag),
    .divisor  ({1'b0, ent.hits} + DIVR_W'(1)),
    .quot     (quot),
    .done     (div_done)
  );

  // gate test on registered squares
  always_comb begin
    logic [32:0] dsum;
    dsum   = {1'b0, dx2} + {1'b0, dy2};
    gate   = !far && (dsum < {1'b0, r2});
    lab_eq = (ent.label == dlab_r);
    side   = (ent.label == LABEL_UNKNOWN) != (dlab_r == LABEL_UNKNOWN);
  end

  // restore sign of each truncated quotient
  always_comb begin
    logic [NUM_W-1:0] sq [3];
    for (int l = 0; l < 3; l++) begin
      sq[l] = neg[l] ? (NUM_W'(0) - quot[l]) : quot[l];
    end
    mx = sq[0][POS_W-1:0];
    my = sq[1][POS_W-1:0];
    mz = sq[2][POS_W-1:0];
    new_lab  = (ent.label == LABEL_UNKNOWN) ? dlab_r : ent.label;
    new_hits = (ent.hits == HITS_MAX) ? ent.hits : ent.hits + 1'b1;
  end

  assign idx_inc1 = idx + 1'b1;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sel;
    wr_ent    = '{x: mx, y: my, z: mz, label: new_lab, hits: new_hits};
    if (cmd.res_load && cmd.res_kind == KIND_MERGED) begin
      ram_we = 1'b1;
    end else if (cmd.res_load && cmd.res_kind == KIND_ADDED) begin
      ram_we    = 1'b1;
      ram_waddr = occ[IDX_W-1:0];
      wr_ent    = '{x: dx_r, y: dy_r, z: dz_r, label: dlab_r, hits: HIT_W'(1)};
    end
  end

  always_comb begin
    stat.occ_zero  = (occ == '0);
    stat.full      = (occ == CNT_W'(CAPACITY));
    stat.idx_end   = (idx_inc1 == occ);
    stat.hit_eq    = gate && lab_eq;
    stat.sel_valid = sel_valid;
    stat.qual      = (ent.hits >= min_det);
    stat.any_q     = any_q;
    stat.is_last   = (idx[IDX_W-1:0] == last_idx);
    stat.div_done  = div_done;
    stat.out_free  = !out_valid || out_ready;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      r2      <= 32'd65536;
      min_det <= 16'd2;
    end else if (cfg_we) begin
      if (cfg_index == CFG_RADIUS) begin
        r2 <= cfg_data * cfg_data;
      end else if (cfg_index == CFG_MIN) begin
        min_det <= cfg_data;
      end
    end
  end

  // control state of the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      idx       <= '0;
      sel_valid <= 1'b0;
      any_q     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.capture || cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx_inc1;
      end
      if (cmd.capture) begin
        sel_valid <= 1'b0;
        any_q     <= 1'b0;
      end else begin
        if (cmd.gate_upd && gate && (lab_eq || side)) begin
          sel_valid <= 1'b1;
        end
        if (cmd.pub_upd && stat.qual) begin
          any_q <= 1'b1;
        end
      end
      if (cmd.res_load && cmd.res_kind == KIND_ADDED) begin
        occ <= occ + 1'b1;
      end else if (cmd.res_load && cmd.res_kind == KIND_RESET) begin
        occ <= '0;
      end
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    logic signed [32:0] ddx, ddy;
    logic [32:0]        ax, ay;
    logic signed [48:0] nm [3];
    logic signed [48:0] hn;
    ddx = 33'(ent.x) - 33'(dx_r);
    ddy = 33'(ent.y) - 33'(dy_r);
    ax  = ddx[32] ? 33'(-ddx) : 33'(ddx);
    ay  = ddy[32] ? 33'(-ddy) : 33'(ddy);
    hn  = 49'(signed'({1'b0, ent.hits}));
    nm[0] = 49'(ent.x) * hn + 49'(dx_r);
    nm[1] = 49'(ent.y) * hn + 49'(dy_r);
    nm[2] = 49'(ent.z) * hn + 49'(dz_r);

    if (cmd.capture) begin
      dx_r   <= det_x;
      dy_r   <= det_y;
      dz_r   <= det_z;
      dlab_r <= det_label;
    end
    if (cmd.diff_en) begin
      adx <= ax[15:0];
      ady <= ay[15:0];
      far <= (|ax[32:16]) || (|ay[32:16]);
    end
    if (cmd.sq_en) begin
      dx2 <= adx * adx;
      dy2 <= ady * ady;
    end
    if (cmd.gate_upd && gate && (lab_eq || side)) begin
      sel <= idx[IDX_W-1:0];
    end
    if (cmd.pub_upd && stat.qual) begin
      last_idx <= idx[IDX_W-1:0];
    end
    if (cmd.mul_en) begin
      for (int l = 0; l < 3; l++) begin
        neg[l] <= nm[l][48];
        mag[l] <= nm[l][48] ? NUM_W'(-nm[l]) : NUM_W'(nm[l]);
      end
    end
    if (cmd.res_load) begin
      kind <= cmd.res_kind;
      case (cmd.res_kind)
        KIND_MERGED: begin
          slot         <= SLOT_W'(sel);
          pos_x        <= mx;
          pos_y        <= my;
          pos_z        <= mz;
          label_out    <= new_lab;
          count_out    <= new_hits;
          entries_used <= USED_W'(occ);
          last         <= 1'b1;
        end
        KIND_ADDED: begin
          slot         <= SLOT_W'(occ);
          pos_x        <= dx_r;
          pos_y        <= dy_r;
          pos_z        <= dz_r;
          label_out    <= dlab_r;
          count_out    <= HIT_W'(1);
          entries_used <= USED_W'(occ + 1'b1);
          last         <= 1'b1;
        end
        KIND_DROP: begin
          slot         <= '0;
          pos_x        <= dx_r;
          pos_y        <= dy_r;
          pos_z        <= dz_r;
          label_out    <= dlab_r;
          count_out    <= '0;
          entries_used <= USED_W'(occ);
          last         <= 1'b1;
        end
        KIND_MAP: begin
          slot         <= SLOT_W'(idx);
          pos_x        <= ent.x;
          pos_y        <= ent.y;
          pos_z        <= ent.z;
          label_out    <= ent.label;
          count_out    <= ent.hits;
          entries_used <= USED_W'(occ);
          last         <= (idx[IDX_W-1:0] == last_idx);
        end
        KIND_RESET: begin
          slot         <= '0;
          pos_x        <= '0;
          pos_y        <= '0;
          pos_z        <= '0;
          label_out    <= '0;
          count_out    <= HIT_W'(occ);
          entries_used <= '0;
          last         <= 1'b1;
        end
        default: begin
          slot         <= '0;
          pos_x        <= '0;
          pos_y        <= '0;
          pos_z        <= '0;
          label_out    <= '0;
          count_out    <= '0;
          entries_used <= USED_W'(occ);
          last         <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ----- rtl/labeled_detection_track_table.sv -----
// Detection: gate scan (read, difference, square, compare) over the occupied entries, stopping early at
// a gated entry with the same label, then the running mean (48-step three-lane divider) when matched; else add/drop.
// Publish: one pass over the entries to find the last qualifying slot, then a second pass to stream.
// One item in work at a time; a new item is taken while the last result waits.
// Synchronous active-high reset empties the table and restores register defaults.
module labeled_detection_track_table (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ldt_pkg::OP_W-1:0]           op,
  input  logic signed [ldt_pkg::POS_W-1:0]   det_x,
  input  logic signed [ldt_pkg::POS_W-1:0]   det_y,
  input  logic signed [ldt_pkg::POS_W-1:0]   det_z,
  input  logic [ldt_pkg::LAB_W-1:0]          det_label,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ldt_pkg::KIND_W-1:0]         kind,
  output logic [ldt_pkg::SLOT_W-1:0]         slot,
  output logic signed [ldt_pkg::POS_W-1:0]   pos_x,
  output logic signed [ldt_pkg::POS_W-1:0]   pos_y,
  output logic signed [ldt_pkg::POS_W-1:0]   pos_z,
  output logic [ldt_pkg::LAB_W-1:0]          label_out,
  output logic [ldt_pkg::HIT_W-1:0]          count_out,
  output logic [ldt_pkg::USED_W-1:0]         entries_used,
  output logic                               last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ldt_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [ldt_pkg::CFG_W-1:0]          cfg_data
);
  import ldt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  ldt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ldt_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .det_x        (det_x),
    .det_y        (det_y),
    .det_z        (det_z),
    .det_label    (det_label),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .kind         (kind),
    .slot         (slot),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .label_out    (label_out),
    .count_out    (count_out),
    .entries_used (entries_used),
    .last         (last)
  );

endmodule

// ----- rtl/ldt_checker.sv -----
// Port-level checks for the track table, attached to the top level by bind.
// Depends on ldt_pkg.
module ldt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ldt_pkg::KIND_W-1:0]   kind,
  input logic [ldt_pkg::USED_W-1:0]   entries_used,
  input logic                         last
);
  import ldt_pkg::*;

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_kind_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(kind) && $stable(entries_used))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_RESET |-> entries_used == '0 && last)
    else $error("reset result shows occupied entries");

  a_used_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entries_used <= USED_W'(CAPACITY))
    else $error("occupancy beyond capacity");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_MAP |-> last)
    else $error("single result without last");

endmodule

bind labeled_detection_track_table ldt_checker u_ldt_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .kind         (kind),
  .entries_used (entries_used),
  .last         (last)
);
